/* hdl/dasc_pkg.sv */
// Shared types and constants for the deadlock-avoidance safety check block.
// No dependencies; every other file in hdl/ imports this package.
package dasc_pkg;

   localparam int unsigned COUNT_W  = 8;   // one resource count
   localparam int unsigned WORK_W   = 12;  // work vector element
   localparam int unsigned SEQ_W    = 3;   // process index in a result beat
   localparam int unsigned PCOUNT_W = 4;   // process count register
   localparam int unsigned LEN_W    = 4;   // sequence length, 0..MAX_SEQ
   localparam int unsigned MAX_SEQ  = 8;   // longest safe sequence reported
   localparam int unsigned FIELDS   = 4;   // amount and need fields on the port

   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [WORK_W-1:0]  work_type;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_FREE    = 2'd1,
      OP_CHECK   = 2'd2,
      OP_REQUEST = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_LIMIT  = 2'd1,
      ST_UNSAFE = 2'd2,
      ST_LOADED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_SCAN = 2'd2,
      S_EMIT = 2'd3
   } state_type;

   // Commands broadcast from the sequencer to every process lane.
   typedef struct packed {
      logic load_row;
      logic grant;
      logic undo;
      logic scan_clear;
   } lane_cmd_type;

   // What one lane reports back about its own row.
   typedef struct packed {
      logic fits;
      logic over;
   } lane_stat_type;

endpackage

/* hdl/dasc_lane.sv */
// One process lane: holds the allocation row, the need row and the finish mark
// of a single process, and tests them against the work vector. Uses dasc_pkg.
module dasc_lane
   import dasc_pkg::*;
#(
   parameter int unsigned RESOURCES = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lane_cmd_type                          cmd,
   input  logic                                  sel,
   input  logic                                  active,
   input  logic                                  picked,
   input  logic [RESOURCES-1:0][COUNT_W-1:0]     amount,
   input  logic [RESOURCES-1:0][COUNT_W-1:0]     need_load,
   input  logic [RESOURCES-1:0][WORK_W-1:0]      work,
   output lane_stat_type                         stat,
   output logic [RESOURCES-1:0][COUNT_W-1:0]     alloc_row
);

   logic [RESOURCES-1:0][COUNT_W-1:0] alloc_ff, alloc_in;
   logic [RESOURCES-1:0][COUNT_W-1:0] need_ff, need_in;
   logic                              finished_ff, finished_in;

   always_comb begin
      alloc_in    = alloc_ff;
      need_in     = need_ff;
      finished_in = finished_ff;
      if (cmd.scan_clear) begin
         finished_in = 1'b0;
      end
      if (picked) begin
         finished_in = 1'b1;
      end
      if (sel) begin
         for (int j = 0; j < RESOURCES; j++) begin
            if (cmd.load_row) begin
               alloc_in[j] = amount[j];
               need_in[j]  = need_load[j];
            end else if (cmd.grant) begin
               alloc_in[j] = alloc_ff[j] + amount[j];
               need_in[j]  = need_ff[j] - amount[j];
            end else if (cmd.undo) begin
               alloc_in[j] = alloc_ff[j] - amount[j];
               need_in[j]  = need_ff[j] + amount[j];
            end
         end
      end
   end

   // A request is over the limit when it exceeds the need or would carry the
   // allocation past the count width.
   always_comb begin
      logic              fit_all;
      logic              over_any;
      logic [COUNT_W:0]  sum;
      fit_all  = active & ~finished_ff;
      over_any = 1'b0;
      for (int j = 0; j < RESOURCES; j++) begin
         sum = {1'b0, amount[j]} + {1'b0, alloc_ff[j]};
         if ({{(WORK_W-COUNT_W){1'b0}}, need_ff[j]} > work[j]) begin
            fit_all = 1'b0;
         end
         if ((amount[j] > need_ff[j]) || sum[COUNT_W]) begin
            over_any = 1'b1;
         end
      end
      stat.fits = fit_all;
      stat.over = over_any;
   end

   assign alloc_row = alloc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff    <= '0;
         need_ff     <= '0;
         finished_ff <= 1'b0;
      end else begin
         alloc_ff    <= alloc_in;
         need_ff     <= need_in;
         finished_ff <= finished_in;
      end
   end

endmodule

/* hdl/dasc_merge.sv */
// Merging stage: picks the lowest lane whose need fits and adds that lane's
// allocation to the work vector. Uses dasc_pkg.
module dasc_merge
   import dasc_pkg::*;
#(
   parameter int unsigned PROCESSES = 8,
   parameter int unsigned RESOURCES = 4,
   parameter int unsigned PIDX_W    = 3
) (
   input  logic [PROCESSES-1:0]                           fits,
   input  logic [PROCESSES-1:0][RESOURCES-1:0][COUNT_W-1:0] allocs,
   input  logic [RESOURCES-1:0][WORK_W-1:0]                work,
   output logic                                           pick_valid,
   output logic [PROCESSES-1:0]                           pick_onehot,
   output logic [PIDX_W-1:0]                              pick_idx,
   output logic [RESOURCES-1:0][WORK_W-1:0]                work_next
);

   logic [PROCESSES-1:0]                 one_w;
   logic [RESOURCES-1:0][COUNT_W-1:0]    alloc_sel;

   assign one_w       = {{(PROCESSES-1){1'b0}}, 1'b1};
   // Two's complement trick isolates the lowest set bit.
   assign pick_onehot = fits & (~fits + one_w);
   assign pick_valid  = |fits;

   always_comb begin
      pick_idx  = '0;
      alloc_sel = '0;
      for (int i = 0; i < PROCESSES; i++) begin
         if (pick_onehot[i]) begin
            pick_idx  = pick_idx | PIDX_W'(i);
            alloc_sel = alloc_sel | allocs[i];
         end
      end
      for (int j = 0; j < RESOURCES; j++) begin
         work_next[j] = work[j] + {{(WORK_W-COUNT_W){1'b0}}, alloc_sel[j]};
      end
   end

endmodule

/* hdl/deadlock_avoidance_safety_check_top.sv */
// Banker's-algorithm safety check: process lanes, merging stage and sequencer.
// Depends on dasc_pkg, dasc_lane and dasc_merge.
//
// One input beat is taken only while the block is idle. Load row and set free
// counts give one result beat. A safety check or a granted request takes one
// scan step per process found (at most the process count n), each step
// through the lanes and the merging stage, then gives n result beats, one per
// cycle while the output does not stall. A rejected or unsafe outcome gives a
// single beat instead of the sequence. The process count register takes
// effect as soon as it is written, also while an item is in progress.
module deadlock_avoidance_safety_check_top
   import dasc_pkg::*;
#(
   parameter int unsigned PROCESSES = 8,
   parameter int unsigned RESOURCES = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_operation,
   input  logic [2:0]           req_process,
   input  logic [7:0]           req_amount_0,
   input  logic [7:0]           req_amount_1,
   input  logic [7:0]           req_amount_2,
   input  logic [7:0]           req_amount_3,
   input  logic [7:0]           req_need_0,
   input  logic [7:0]           req_need_1,
   input  logic [7:0]           req_need_2,
   input  logic [7:0]           req_need_3,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [2:0]           rsp_sequence_process,
   output logic                 rsp_last,
   input  logic                 csr_write_enable,
   input  logic [3:0]           csr_write_data
);

   localparam int unsigned PIDX_W  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
   localparam int unsigned LIMIT_N = (PROCESSES < MAX_SEQ) ? PROCESSES : MAX_SEQ;

   state_type state_ff, state_in;

   logic [PCOUNT_W-1:0] pcount_ff;
   logic [PCOUNT_W-1:0] n_cur;

   logic [1:0]                         op_ff;
   logic [2:0]                         proc_ff;
   logic [RESOURCES-1:0][COUNT_W-1:0]  amt_ff;
   logic [RESOURCES-1:0][COUNT_W-1:0]  need_ff;
   count_type                          amt_port [FIELDS];
   count_type                          need_port [FIELDS];

   logic [RESOURCES-1:0][COUNT_W-1:0]  free_ff, free_in;
   logic [RESOURCES-1:0][WORK_W-1:0]   work_ff, work_in;

   logic [LEN_W-1:0]       len_ff, len_in;
   logic [SEQ_W-1:0]       emit_ff, emit_in;
   logic                   single_ff, single_in;
   status_type             code_ff, code_in;
   logic                   granted_ff, granted_in;
   logic [SEQ_W-1:0]       seq_ff [MAX_SEQ];
   logic                   seq_we;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [2:0]             rsp_proc_ff, rsp_proc_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   out_load;

   lane_cmd_type           lane_cmd;
   lane_stat_type          lane_stat [PROCESSES];
   logic [PROCESSES-1:0]   lane_sel;
   logic [PROCESSES-1:0]   lane_active;
   logic [PROCESSES-1:0]   lane_fits;
   logic [PROCESSES-1:0]   lane_over;
   logic [PROCESSES-1:0]   lane_picked;
   logic [PROCESSES-1:0][RESOURCES-1:0][COUNT_W-1:0] lane_alloc;

   logic                   pick_valid;
   logic [PROCESSES-1:0]   pick_onehot;
   logic [PIDX_W-1:0]      pick_idx;
   logic [RESOURCES-1:0][WORK_W-1:0] work_next;

   logic                   accept;
   logic                   req_bad;
   logic                   emit_last;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = (state_ff != S_IDLE) | reset;

   assign amt_port[0]  = req_amount_0;
   assign amt_port[1]  = req_amount_1;
   assign amt_port[2]  = req_amount_2;
   assign amt_port[3]  = req_amount_3;
   assign need_port[0] = req_need_0;
   assign need_port[1] = req_need_1;
   assign need_port[2] = req_need_2;
   assign need_port[3] = req_need_3;

   // Processes in use: zero counts as one, the top saturates at the smaller of PROCESSES and MAX_SEQ.
   always_comb begin
      if (pcount_ff == '0) begin
         n_cur = PCOUNT_W'(1);
      end else if (pcount_ff > PCOUNT_W'(LIMIT_N)) begin
         n_cur = PCOUNT_W'(LIMIT_N);
      end else begin
         n_cur = pcount_ff;
      end
   end

   for (genvar i = 0; i < PROCESSES; i++) begin : g_lane
      assign lane_sel[i]    = (int'(proc_ff) == i);
      assign lane_active[i] = (i < int'(n_cur));
      assign lane_picked[i] = pick_onehot[i] & (state_ff == S_SCAN);
      assign lane_fits[i]   = lane_stat[i].fits;
      assign lane_over[i]   = lane_stat[i].over;

      dasc_lane #(
         .RESOURCES (RESOURCES)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .cmd       (lane_cmd),
         .sel       (lane_sel[i]),
         .active    (lane_active[i]),
         .picked    (lane_picked[i]),
         .amount    (amt_ff),
         .need_load (need_ff),
         .work      (work_ff),
         .stat      (lane_stat[i]),
         .alloc_row (lane_alloc[i])
      );
   end

   dasc_merge #(
      .PROCESSES (PROCESSES),
      .RESOURCES (RESOURCES),
      .PIDX_W    (PIDX_W)
   ) u_merge (
      .fits        (lane_fits),
      .allocs      (lane_alloc),
      .work        (work_ff),
      .pick_valid  (pick_valid),
      .pick_onehot (pick_onehot),
      .pick_idx    (pick_idx),
      .work_next   (work_next)
   );

   // A request is rejected for a process not in use, for a row over its limit,
   // or for more than the free counts.
   always_comb begin
      req_bad = ({1'b0, proc_ff} >= n_cur) | (|(lane_over & lane_sel));
      for (int j = 0; j < RESOURCES; j++) begin
         if (amt_ff[j] > free_ff[j]) begin
            req_bad = 1'b1;
         end
      end
   end

   assign emit_last = single_ff | (({1'b0, emit_ff} + LEN_W'(1)) == len_ff);
   assign out_load  = (state_ff == S_EMIT) & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      state_in   = state_ff;
      free_in    = free_ff;
      work_in    = work_ff;
      len_in     = len_ff;
      emit_in    = emit_ff;
      single_in  = single_ff;
      code_in    = code_ff;
      granted_in = granted_ff;
      lane_cmd   = '0;
      seq_we     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (op_type'(op_ff))
               OP_LOAD: begin
                  lane_cmd.load_row = 1'b1;
                  single_in = 1'b1;
                  code_in   = ST_LOADED;
                  state_in  = S_EMIT;
               end
               OP_FREE: begin
                  free_in   = amt_ff;
                  single_in = 1'b1;
                  code_in   = ST_LOADED;
                  state_in  = S_EMIT;
               end
               OP_CHECK: begin
                  for (int j = 0; j < RESOURCES; j++) begin
                     work_in[j] = {{(WORK_W-COUNT_W){1'b0}}, free_ff[j]};
                  end
                  lane_cmd.scan_clear = 1'b1;
                  len_in     = '0;
                  granted_in = 1'b0;
                  state_in   = S_SCAN;
               end
               OP_REQUEST: begin
                  if (req_bad) begin
                     single_in = 1'b1;
                     code_in   = ST_LIMIT;
                     state_in  = S_EMIT;
                  end else begin
                     // Grant tentatively; the scan starts from the reduced free counts.
                     for (int j = 0; j < RESOURCES; j++) begin
                        free_in[j] = free_ff[j] - amt_ff[j];
                        work_in[j] = {{(WORK_W-COUNT_W){1'b0}}, free_in[j]};
                     end
                     lane_cmd.grant      = 1'b1;
                     lane_cmd.scan_clear = 1'b1;
                     len_in     = '0;
                     granted_in = 1'b1;
                     state_in   = S_SCAN;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SCAN: begin
            if (pick_valid) begin
               seq_we  = 1'b1;
               work_in = work_next;
               len_in  = len_ff + LEN_W'(1);
               if (len_in == n_cur) begin
                  single_in = 1'b0;
                  emit_in   = '0;
                  state_in  = S_EMIT;
               end
            end else begin
               single_in = 1'b1;
               code_in   = ST_UNSAFE;
               state_in  = S_EMIT;
               if (granted_ff) begin
                  lane_cmd.undo = 1'b1;
                  for (int j = 0; j < RESOURCES; j++) begin
                     free_in[j] = free_ff[j] + amt_ff[j];
                  end
               end
            end
         end
         S_EMIT: begin
            if (out_load) begin
               if (emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  emit_in = emit_ff + SEQ_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = out_load | (rsp_valid_ff & rsp_stall);
      rsp_status_in = single_ff ? code_ff : ST_OK;
      rsp_proc_in   = single_ff ? '0 : seq_ff[emit_ff];
      rsp_last_in   = emit_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pcount_ff    <= PCOUNT_W'(8);
         free_ff      <= '0;
         work_ff      <= '0;
         len_ff       <= '0;
         emit_ff      <= '0;
         single_ff    <= 1'b1;
         code_ff      <= ST_LOADED;
         granted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_write_enable) begin
            pcount_ff <= csr_write_data;
         end
         free_ff      <= free_in;
         work_ff      <= work_in;
         len_ff       <= len_in;
         emit_ff      <= emit_in;
         single_ff    <= single_in;
         code_ff      <= code_in;
         granted_ff   <= granted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and result payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_operation;
         proc_ff <= req_process;
         for (int j = 0; j < RESOURCES; j++) begin
            amt_ff[j]  <= amt_port[j];
            need_ff[j] <= need_port[j];
         end
      end
      if (seq_we) begin
         seq_ff[len_ff[SEQ_W-1:0]] <= SEQ_W'(pick_idx);
      end
      if (out_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_proc_ff   <= rsp_proc_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_sequence_process = rsp_proc_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

/* hdl/dasc_checker.sv */
// Port-level checks for the safety check block, bound to the top level.
// Depends on dasc_pkg and deadlock_avoidance_safety_check_top.
module dasc_checker
   import dasc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic [2:0] rsp_sequence_process,
   input logic       rsp_last
);

   // A result beat that waits keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_sequence_process) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Every status other than a sequence item is a lone beat with index zero.
   a_single_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_last && (rsp_sequence_process == 3'd0))
      else $error("status beat is not a single final beat");

   // The block works on one item at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second beat taken while an item is in progress");

   a_no_accept_mid_sequence: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("input taken before the sequence was delivered");

endmodule

bind deadlock_avoidance_safety_check_top dasc_checker u_dasc_checker (.*);
